// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that reset disables.
`define LCAR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("load cell reader check failed");

// Clocked assertion that also holds during reset.
`define LCAR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("load cell reader check failed");

`endif

// ===== rtl/lcar_pkg.sv =====
// Package: shared types, codes and constants of the load cell reader.
`timescale 1ns / 1ps
package lcar_pkg;

   localparam int RAW_BITS      = 24;
   localparam int WEIGHT_BITS   = 28;
   localparam int GAP_BITS      = 16;
   localparam int DIVIDEND_BITS = 28;
   localparam int DIV_STEPS     = DIVIDEND_BITS;
   localparam int COUNT_BITS    = 5;

   localparam logic [RAW_BITS-1:0]    RAW_FLIP      = 24'h800000;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_OFFSET = 28'd5;
   localparam logic [GAP_BITS-1:0]    GAP_RESET     = 16'd16;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_TARE  = 2'd1;
   localparam logic [1:0] CMD_WEIGH = 2'd2;

   localparam logic REG_GAP = 1'b0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;      // begin a reading, clear shift register and count
      logic kind;       // 0 tare, 1 weigh (with start)
      logic shift;      // shift the sample register left
      logic sample;     // OR the data line into bit 0, advance count
      logic flip;       // flip the sign bit
      logic finish;     // store raw, tare or weight
      logic flag_load;  // load the response flag registers
      logic clk_pin;
      logic busy;
      logic done;
   } lcar_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_last;  // the coming sample is the last data bit
      logic div_needed;  // finishing now starts a division
      logic div_done;    // weight written this cycle
   } lcar_sts_type;

endpackage

// ===== rtl/lcar_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lcar_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [lcar_pkg::DIVIDEND_BITS-1:0] dividend,
   input  logic [lcar_pkg::GAP_BITS-1:0]      divisor,
   output logic done,
   output logic [lcar_pkg::DIVIDEND_BITS-1:0] quotient
);
   import lcar_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [GAP_BITS-1:0]      dvs_ff, dvs_in;
   logic [GAP_BITS-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [GAP_BITS:0]        trial;
   logic [GAP_BITS:0]        diff;
   logic                     ge;

   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         // a zero divisor counts as one
         dvs_in  = (divisor == '0) ? GAP_BITS'(1) : divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[GAP_BITS-1:0] : trial[GAP_BITS-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == COUNT_BITS'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/lcar_datapath.sv =====
// Datapath: sample shift register, tare, raw and weight registers, response flags.
`timescale 1ns / 1ps
module lcar_datapath (
   input  logic clock,
   input  logic reset,
   input  lcar_pkg::lcar_cmd_type cmd,
   input  logic data_pin,
   input  logic [lcar_pkg::GAP_BITS-1:0] gap_q4,
   output lcar_pkg::lcar_sts_type sts,
   output logic clock_pin,
   output logic busy_res,
   output logic done_res,
   output logic done_kind,
   output logic [lcar_pkg::RAW_BITS-1:0]    raw_reading,
   output logic [lcar_pkg::WEIGHT_BITS-1:0] weight
);
   import lcar_pkg::*;

   logic [RAW_BITS-1:0]      shift_ff, shift_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic                     kind_ff, kind_in;
   logic [RAW_BITS-1:0]      tare_ff, tare_in;
   logic [RAW_BITS-1:0]      raw_ff, raw_in;
   logic [WEIGHT_BITS-1:0]   weight_ff, weight_in;
   logic                     clk_pin_ff, busy_ff, done_ff, done_kind_ff;
   logic                     above_tare;
   logic                     div_start;
   logic                     div_done;
   logic [DIVIDEND_BITS-1:0] dividend;
   logic [DIVIDEND_BITS-1:0] quotient;
   logic [RAW_BITS-1:0]      delta;

   assign above_tare = shift_ff > tare_ff;
   assign delta      = shift_ff - tare_ff;
   assign dividend   = {delta, 4'b0000};
   assign div_start  = cmd.finish && kind_ff && above_tare;

   lcar_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (gap_q4),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      shift_in  = shift_ff;
      count_in  = count_ff;
      kind_in   = kind_ff;
      tare_in   = tare_ff;
      raw_in    = raw_ff;
      weight_in = weight_ff;
      if (cmd.start) begin
         shift_in = '0;
         count_in = '0;
         kind_in  = cmd.kind;
      end
      if (cmd.shift) begin
         shift_in = {shift_ff[RAW_BITS-2:0], 1'b0};
      end
      if (cmd.sample) begin
         shift_in = {shift_ff[RAW_BITS-1:1], shift_ff[0] | data_pin};
         count_in = count_ff + 1'b1;
      end
      if (cmd.flip) begin
         shift_in = shift_ff ^ RAW_FLIP;
      end
      if (cmd.finish) begin
         raw_in = shift_ff;
         if (!kind_ff) begin
            tare_in = shift_ff;
         end else if (!above_tare) begin
            weight_in = '0;
         end
      end
      if (div_done) begin
         weight_in = quotient + WEIGHT_OFFSET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= '0;
         count_ff  <= '0;
         kind_ff   <= 1'b0;
         tare_ff   <= '0;
         raw_ff    <= '0;
         weight_ff <= '0;
      end else begin
         shift_ff  <= shift_in;
         count_ff  <= count_in;
         kind_ff   <= kind_in;
         tare_ff   <= tare_in;
         raw_ff    <= raw_in;
         weight_ff <= weight_in;
      end
      if (cmd.flag_load) begin
         clk_pin_ff   <= cmd.clk_pin;
         busy_ff      <= cmd.busy;
         done_ff      <= cmd.done;
         done_kind_ff <= cmd.done & kind_ff;
      end
   end

   assign sts.count_last = count_ff >= COUNT_BITS'(RAW_BITS - 1);
   assign sts.div_needed = kind_ff && above_tare;
   assign sts.div_done   = div_done;

   assign clock_pin   = clk_pin_ff;
   assign busy_res    = busy_ff;
   assign done_res    = done_ff;
   assign done_kind   = done_kind_ff;
   assign raw_reading = raw_ff;
   assign weight      = weight_ff;

endmodule

// ===== rtl/lcar_ctrl.sv =====
// Controller: tick sequencer for the converter and transfer handshake.
`timescale 1ns / 1ps
module lcar_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_command,
   input  logic req_data_pin,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  lcar_pkg::lcar_sts_type sts,
   output lcar_pkg::lcar_cmd_type cmd
);
   import lcar_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_WAIT = 3'd1;
   localparam logic [2:0] PH_HIGH = 3'd2;
   localparam logic [2:0] PH_LOW  = 3'd3;
   localparam logic [2:0] PH_P25  = 3'd4;
   localparam logic [2:0] PH_FIN  = 3'd5;

   localparam logic ST_RUN = 1'b0;
   localparam logic ST_DIV = 1'b1;

   logic [2:0] phase_ff, phase_in;
   logic       state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in     = phase_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (req_command == CMD_TARE || req_command == CMD_WEIGH) begin
                  cmd.start = 1'b1;
                  cmd.kind  = (req_command == CMD_WEIGH);
                  phase_in  = PH_WAIT;
               end
            end
            PH_WAIT: begin
               if (!req_data_pin) begin
                  phase_in = PH_HIGH;
               end
            end
            PH_HIGH: begin
               cmd.clk_pin = 1'b1;
               cmd.shift   = 1'b1;
               phase_in    = PH_LOW;
            end
            PH_LOW: begin
               cmd.sample = 1'b1;
               phase_in   = sts.count_last ? PH_P25 : PH_HIGH;
            end
            PH_P25: begin
               cmd.clk_pin = 1'b1;
               cmd.flip    = 1'b1;
               phase_in    = PH_FIN;
            end
            PH_FIN: begin
               cmd.finish = 1'b1;
               cmd.done   = 1'b1;
               phase_in   = PH_IDLE;
               if (sts.div_needed) begin
                  state_in = ST_DIV;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         cmd.busy      = (phase_in != PH_IDLE);
         cmd.flag_load = 1'b1;
         rsp_valid_in  = (state_in == ST_RUN);
      end
      if (state_ff == ST_DIV && sts.div_done) begin
         state_in     = ST_RUN;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/load_cell_adc_reader_with_tare.sv =====
// Top level: serial load cell converter reader with tare and weight scaling.
// Response: a tick transfer shows its response in the cycle after acceptance; the
//   final tick of a weigh reading above tare is answered once the
//   28-step restoring divider that scales the weight is done.
// Throughput: one tick per cycle while responses are taken at once and no weight division runs.
// Reset (synchronous, active high): idle, tare, raw and weight zero, gap_q4 16.
`timescale 1ns / 1ps
module load_cell_adc_reader_with_tare (
   input  logic        clock,
   input  logic        reset,
   // input ticks
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic        req_data_pin,
   // per-tick responses
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_clock_pin,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_done_kind,
   output logic [lcar_pkg::RAW_BITS-1:0]    rsp_raw_reading,
   output logic [lcar_pkg::WEIGHT_BITS-1:0] rsp_weight,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lcar_pkg::*;

   logic [GAP_BITS-1:0] gap_ff, gap_in;
   logic                reg_write;
   lcar_cmd_type        cmd;
   lcar_sts_type        sts;

   // Register file: one word, gap_q4, at byte address 0. The word index is
   // paddr[2]; the byte offset bits are ignored.
   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite && pready && (paddr[2] == REG_GAP);

   always_comb begin
      gap_in = gap_ff;
      if (reg_write) begin
         gap_in = pwdata[GAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_RESET;
      end else begin
         gap_ff <= gap_in;
      end
   end

   assign prdata = (paddr[2] == REG_GAP) ? {{(32-GAP_BITS){1'b0}}, gap_ff} : '0;

   // Controller: walks the tick phases of a reading and owns the transfer
   // handshake. A tick is taken only while the response register is free or
   // drains in the same cycle; the weight division holds off new ticks.
   lcar_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_data_pin (req_data_pin),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .sts          (sts),
      .cmd          (cmd)
   );

   // Datapath: shifts in the 24 data bits MSB first, flips the sign bit,
   // stores the tare or scales (raw - tare) * 16 / gap_q4 + 5, or zero at or below tare.
   lcar_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_pin    (req_data_pin),
      .gap_q4      (gap_ff),
      .sts         (sts),
      .clock_pin   (rsp_clock_pin),
      .busy_res    (rsp_busy_res),
      .done_res    (rsp_done_res),
      .done_kind   (rsp_done_kind),
      .raw_reading (rsp_raw_reading),
      .weight      (rsp_weight)
   );

endmodule

// ===== rtl/lcar_checker.sv =====
// Checker on the top level ports, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcar_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_clock_pin,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic [27:0] rsp_weight
);

   // a finished reading is no longer busy
   `LCAR_ASSERT(a_done_not_busy, clock, reset, (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
   // the converter clock goes high only inside a reading
   `LCAR_ASSERT(a_clk_in_reading, clock, reset, (rsp_valid && rsp_clock_pin) |-> rsp_busy_res)
   // a tick is taken only while the response slot is free or drains
   `LCAR_ASSERT(a_accept_slot, clock, reset, (req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
   // a stalled response holds
   `LCAR_ASSERT(a_rsp_hold, clock, reset,
                (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_weight)))
   // no response is offered in the cycle after reset
   `LCAR_ASSERT_ALWAYS(a_reset_clear, clock, $past(reset) |-> !rsp_valid)

endmodule

bind load_cell_adc_reader_with_tare lcar_checker u_lcar_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_clock_pin (rsp_clock_pin),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_weight    (rsp_weight)
);
